@@ rtl/core/fsi_pkg.sv @@
package fsi_pkg;

  localparam int MaxPoints = 256;
  localparam int AddrW     = $clog2(MaxPoints);
  localparam int CountW    = $clog2(MaxPoints + 1);

  typedef struct packed {
    logic [15:0] first_objective;
    logic [15:0] second_objective;
    logic        last_point;
  } in_item_t;

  typedef struct packed {
    logic [17:0] spacing;
    logic [8:0]  point_count;
    logic        count_overflow;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OUTER,
    ST_OREAD,
    ST_INNER,
    ST_STORE,
    ST_MEAN,
    ST_MWAIT,
    ST_VREAD,
    ST_VACC,
    ST_DIV,
    ST_ROOT,
    ST_DONE
  } state_t;

  localparam logic [0:0] RegNoNeighbour = 1'b0;

endpackage

@@ rtl/core/front_spacing_indicator.sv @@
// Spacing indicator of a two-objective point set.
// Input: pulse start with first_objective, second_objective and last_point
// while busy is low; each accepted item stores one point (Q0.16 pair).
// Loading a point leaves busy low, so points can follow back to back. An
// item with last_point high starts the evaluation: for each stored point a
// scan over all N points through the point memory finds the nearest L1
// neighbor, then a divide for the mean, a variance pass, a second divide
// and a root. Busy stays high until the result is ready (a set of a single
// point skips the evaluation). The result shows in the cycle in which busy
// falls, for one cycle with result_valid high; the receiver cannot stall.
// Points beyond 256 are dropped and flagged in count_overflow.
// Register 0 (byte address 0) holds no_neighbour_distance, the distance
// used when no point differs in both objectives, reset 0x3FFFF.
// Reset empties the set and clears the control; memories need no clearing.
module front_spacing_indicator (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  fsi_pkg::in_item_t    in_item,
  output logic                 result_valid,
  output fsi_pkg::out_item_t   result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [1:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import fsi_pkg::*;

  logic [31:0] pt_mem [MaxPoints];
  logic [17:0] near_mem [MaxPoints];

  state_t state, state_next;
  logic [17:0] no_nb;
  logic [CountW-1:0] held;
  logic        ovf;
  logic [AddrW-1:0] oi, ki;
  logic        kdone;
  logic [31:0] rd_pt, own;
  logic [17:0] rd_near;
  logic [17:0] best;
  logic        found;
  logic [25:0] sum;
  logic [17:0] mean;
  logic [47:0] acc;
  logic        rd_ok;
  logic        div_go, div_done, sq_go, sq_done;
  logic [47:0] div_num, div_den;
  logic [47:0] quot;
  logic [23:0] rt;
  logic        accept;
  logic        pwr;
  logic [16:0] d1, d2;
  logic [17:0] dl1;
  logic        qual;
  logic [17:0] dv;
  logic [35:0] sq;
  logic [17:0] spc;

  assign pready = 1'b1;
  assign pwr    = psel && penable && pwrite;
  assign prdata = (paddr[1:0] == 2'd0) ? {14'd0, no_nb} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) no_nb <= 18'h3FFFF;
    else if (pwr && paddr == {RegNoNeighbour, 1'b0} ) no_nb <= pwdata[17:0];
  end

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // distance of current candidate
  always_comb begin
    d1 = (own[31:16] > rd_pt[31:16]) ? {1'b0, own[31:16] - rd_pt[31:16]}
                                     : {1'b0, rd_pt[31:16] - own[31:16]};
    d2 = (own[15:0] > rd_pt[15:0]) ? {1'b0, own[15:0] - rd_pt[15:0]}
                                   : {1'b0, rd_pt[15:0] - own[15:0]};
    dl1  = {1'b0, d1} + {1'b0, d2};
    qual = (own[31:16] != rd_pt[31:16]) && (own[15:0] != rd_pt[15:0]);
    dv   = (mean > rd_near) ? mean - rd_near : rd_near - mean;
    sq   = dv * dv;
  end

  // memories
  always_ff @(posedge clk) begin
    if (accept && held < CountW'(MaxPoints))
      pt_mem[held[AddrW-1:0]] <= {in_item.first_objective, in_item.second_objective};
    if (state == ST_STORE) near_mem[oi] <= found ? best : no_nb;
    rd_pt   <= pt_mem[(state == ST_OREAD) ? oi : ki];
    rd_near <= near_mem[ki];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept && in_item.last_point)
                  state_next = (held == '0) ? ST_DONE : ST_OUTER;
      ST_OUTER: state_next = ST_OREAD;
      ST_OREAD: state_next = ST_INNER;
      ST_INNER: if (kdone && !rd_ok) state_next = ST_STORE;
      ST_STORE: state_next = (oi == AddrW'(held - 1)) ? ST_MEAN : ST_OUTER;
      ST_MEAN:  state_next = ST_MWAIT;
      ST_MWAIT: if (div_done) state_next = ST_VREAD;
      ST_VREAD: state_next = ST_VACC;
      ST_VACC:  if (kdone && !rd_ok) state_next = ST_DIV;
      ST_DIV:   if (div_done) state_next = ST_ROOT;
      ST_ROOT:  if (sq_done) state_next = ST_DONE;
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // share the divider between the mean and the variance
  assign div_go  = (state == ST_MEAN) || ((state == ST_VACC) && kdone && !rd_ok);
  assign div_num = (state == ST_MEAN) ? 48'(sum) : acc;
  assign div_den = (state == ST_MEAN) ? 48'(held) : 48'(held) - 48'd1;
  assign sq_go   = (state == ST_DIV) && div_done;

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      held  <= '0;
      ovf   <= 1'b0;
      rd_ok <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      result_valid <= (state == ST_DONE);
      if (accept) begin
        if (held < CountW'(MaxPoints)) held <= held + 1'b1;
        else ovf <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          oi  <= '0;
          sum <= '0;
          spc <= '0;
        end
        ST_OUTER: ;
        ST_OREAD: begin
          ki    <= '0;
          kdone <= 1'b0;
          rd_ok <= 1'b0;
          found <= 1'b0;
        end
        ST_INNER: begin
          if (ki == '0 && !rd_ok && !kdone) own <= rd_pt;
          if (rd_ok && qual && (!found || dl1 < best)) begin
            best  <= dl1;
            found <= 1'b1;
          end
          rd_ok <= !kdone;
          if (!kdone) begin
            if (ki == AddrW'(held - 1)) kdone <= 1'b1;
            else ki <= ki + 1'b1;
          end
        end
        ST_STORE: begin
          sum <= sum + 26'(found ? best : no_nb);
          oi  <= oi + 1'b1;
        end
        ST_MEAN: ;
        ST_MWAIT: if (div_done) mean <= quot[17:0];
        ST_VREAD: begin
          ki    <= '0;
          kdone <= 1'b0;
          rd_ok <= 1'b0;
          acc   <= '0;
        end
        ST_VACC: begin
          if (rd_ok) acc <= acc + 48'(sq);
          rd_ok <= !kdone;
          if (!kdone) begin
            if (ki == AddrW'(held - 1)) kdone <= 1'b1;
            else ki <= ki + 1'b1;
          end
        end
        ST_DIV: ;
        ST_ROOT: if (sq_done) spc <= (rt > 24'h3FFFF) ? 18'h3FFFF : rt[17:0];
        ST_DONE: begin
          result.spacing        <= spc;
          result.point_count    <= 9'(held);
          result.count_overflow <= ovf;
          held <= '0;
          ovf  <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  fsi_divider u_div (
    .clk(clk), .rst(rst), .go(div_go), .dividend(div_num),
    .divisor(div_den), .quotient(quot), .done(div_done)
  );

  fsi_sqrt u_sqrt (
    .clk(clk), .rst(rst), .go(sq_go), .radicand(quot), .root(rt), .done(sq_done)
  );

  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == ST_DONE)) else $error("stray result");
  a_held_range: assert property (@(posedge clk) disable iff (rst)
    held <= CountW'(MaxPoints)) else $error("count out of range");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INNER) |-> !accept) else $error("accept while scanning");
endmodule

@@ rtl/core/fsi_divider.sv @@
module fsi_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [47:0] dividend,
  input  logic [47:0] divisor,
  output logic [47:0] quotient,
  output logic        done
);
  import fsi_pkg::*;

  logic [47:0] rem;
  logic [47:0] quo;
  logic [47:0] dsr;
  logic [5:0]  cnt;
  logic        run;
  logic [48:0] trial;

  assign trial = {rem, quo[47]} - {1'b0, dsr};

  // shift one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        rem <= '0;
        quo <= dividend;
        dsr <= divisor;
        cnt <= 6'd0;
        run <= 1'b1;
      end else if (run) begin
        if (!trial[48]) begin
          rem <= trial[47:0];
          quo <= {quo[46:0], 1'b1};
        end else begin
          rem <= {rem[46:0], quo[47]};
          quo <= {quo[46:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd47) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;
endmodule

@@ rtl/core/fsi_sqrt.sv @@
module fsi_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [47:0] radicand,
  output logic [23:0] root,
  output logic        done
);
  import fsi_pkg::*;

  logic [47:0] v;
  logic [47:0] res;
  logic [47:0] bitv;
  logic        run;
  logic [47:0] trial;

  assign trial = res + bitv;

  // resolve one root bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        v    <= radicand;
        res  <= '0;
        bitv <= 48'h4000_0000_0000;
        run  <= 1'b1;
      end else if (run) begin
        if (v >= trial) begin
          v   <= v - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv == 48'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = res[23:0];
endmodule
